// ===== rtl/gdd_pkg.sv =====
`default_nettype none
package gdd_pkg;

    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int SERIAL_W = 24;
    localparam int DIFF_W   = 23;
    localparam int WIDE_W   = 25;

    // register stages in each date conversion
    localparam int CONV_STAGES = 3;

    // floor(x / 25) = (x * RECIP_25) >> RECIP_SH for x below 4096
    localparam int RECIP_25 = 1311;
    localparam int RECIP_SH = 15;
    localparam int PROD_W   = 23;

    localparam logic signed [WIDE_W-1:0] DIFF_MAX = 25'sd4194303;
    localparam logic signed [WIDE_W-1:0] DIFF_MIN = -25'sd4194304;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    typedef logic signed [SERIAL_W-1:0] t_serial;

    typedef struct packed {
        t_serial serial;
        logic    ok;
    } t_date_res;

    // days in the months before month m of a common year
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] m);
        logic [8:0] v;
        case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd365;
        endcase
        return v;
    endfunction

    // month length, zero for a month that does not exist
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] v;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: v = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    v = 5'd30;
            4'd2:    v = leap ? 5'd29 : 5'd28;
            default: v = 5'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/gdd_date_conv.sv =====
`default_nettype none
module gdd_date_conv (
    input  wire logic                      i_clk,
    input  wire logic [gdd_pkg::YEAR_W-1:0]  i_year,
    input  wire logic [gdd_pkg::MONTH_W-1:0] i_month,
    input  wire logic [gdd_pkg::DAY_W-1:0]   i_day,
    output gdd_pkg::t_date_res             o_res
);
    import gdd_pkg::*;

    // stage 1: year splits, quotients by 25 via reciprocal
    logic [YEAR_W-1:0]  r_s1_year, r_s1_p;
    logic [MONTH_W-1:0] r_s1_month;
    logic [DAY_W-1:0]   r_s1_day;
    logic [11:0]        r_s1_q4p, r_s1_qy;
    logic [7:0]         r_s1_q100p, r_s1_qy25;
    logic               r_s1_y0;

    logic [YEAR_W-1:0]  n_s1_p;
    logic [11:0]        n_s1_q4p, n_s1_qy;
    logic [PROD_W-1:0]  n_prod_p, n_prod_y;

    always_comb begin
        n_s1_p   = i_year - YEAR_W'(1);
        n_s1_q4p = n_s1_p[YEAR_W-1:2];
        n_s1_qy  = i_year[YEAR_W-1:2];
        n_prod_p = PROD_W'(n_s1_q4p) * PROD_W'(RECIP_25);
        n_prod_y = PROD_W'(n_s1_qy) * PROD_W'(RECIP_25);
    end

    always_ff @(posedge i_clk) begin
        r_s1_year  <= i_year;
        r_s1_month <= i_month;
        r_s1_day   <= i_day;
        r_s1_p     <= n_s1_p;
        r_s1_q4p   <= n_s1_q4p;
        r_s1_qy    <= n_s1_qy;
        r_s1_q100p <= n_prod_p[PROD_W-1:RECIP_SH];
        r_s1_qy25  <= n_prod_y[PROD_W-1:RECIP_SH];
        r_s1_y0    <= (i_year == '0);
    end

    // stage 2: days in earlier years, leap flag
    t_serial            r_s2_prior;
    logic               r_s2_leap;
    logic [MONTH_W-1:0] r_s2_month;
    logic [DAY_W-1:0]   r_s2_day;

    t_serial     n_s2_prior;
    logic        n_s2_leap;
    logic [12:0] n_rem25;

    always_comb begin
        n_rem25 = 13'(r_s1_qy) - 13'(r_s1_qy25) * 13'd25;
        n_s2_leap = (r_s1_year[1:0] == 2'b00) &&
                    ((n_rem25 != '0) || (r_s1_qy25[1:0] == 2'b00));
        if (r_s1_y0) begin
            n_s2_prior = -SERIAL_W'(365);
        end else begin
            n_s2_prior = SERIAL_W'(r_s1_p) * SERIAL_W'(365) + SERIAL_W'(r_s1_q4p)
                         - SERIAL_W'(r_s1_q100p) + SERIAL_W'(r_s1_q100p[7:2]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_prior <= n_s2_prior;
        r_s2_leap  <= n_s2_leap;
        r_s2_month <= r_s1_month;
        r_s2_day   <= r_s1_day;
    end

    // stage 3: add months and day, check the date
    t_date_res r_s3_res;
    t_date_res n_s3_res;
    logic      n_leap_day;

    always_comb begin
        n_leap_day = r_s2_leap && (r_s2_month > MONTH_FEB);
        n_s3_res.serial = r_s2_prior + SERIAL_W'(days_before(r_s2_month))
                          + SERIAL_W'(r_s2_day) + SERIAL_W'(n_leap_day);
        n_s3_res.ok = (r_s2_day != '0) && (r_s2_month >= MONTH_JAN) &&
                      (r_s2_month <= MONTH_DEC) &&
                      (r_s2_day <= month_len(r_s2_month, r_s2_leap));
    end

    always_ff @(posedge i_clk) begin
        r_s3_res <= n_s3_res;
    end

    assign o_res = r_s3_res;

endmodule
`default_nettype wire

// ===== rtl/gdd_compare.sv =====
`default_nettype none
module gdd_compare (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_vld,
    input  wire logic                     i_eq,
    input  wire gdd_pkg::t_date_res       i_first,
    input  wire gdd_pkg::t_date_res       i_second,
    output logic                          o_strobe,
    output logic [gdd_pkg::DIFF_W-1:0]    o_diff,
    output logic                          o_first_valid,
    output logic                          o_second_valid,
    output logic                          o_first_earlier,
    output logic                          o_first_later,
    output logic                          o_equal
);
    import gdd_pkg::*;

    logic               r_strobe;
    logic [DIFF_W-1:0]  r_diff;
    logic               r_fv, r_sv, r_lt, r_gt, r_eq;

    logic signed [WIDE_W-1:0] n_wide;
    logic [DIFF_W-1:0]        n_diff;

    always_comb begin
        n_wide = WIDE_W'(i_first.serial) - WIDE_W'(i_second.serial);
        if (n_wide > DIFF_MAX) begin
            n_diff = DIFF_MAX[DIFF_W-1:0];
        end else if (n_wide < DIFF_MIN) begin
            n_diff = DIFF_MIN[DIFF_W-1:0];
        end else begin
            n_diff = n_wide[DIFF_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= n_diff;
        r_fv   <= i_first.ok;
        r_sv   <= i_second.ok;
        r_lt   <= i_first.serial < i_second.serial;
        r_gt   <= i_first.serial > i_second.serial;
        r_eq   <= i_eq;
    end

    assign o_strobe        = r_strobe;
    assign o_diff          = r_diff;
    assign o_first_valid   = r_fv;
    assign o_second_valid  = r_sv;
    assign o_first_earlier = r_lt;
    assign o_first_later   = r_gt;
    assign o_equal         = r_eq;

endmodule
`default_nettype wire

// ===== rtl/gregorian_date_difference_top.sv =====
// Throughput: one item per cycle; three conversion stages and one compare stage.
// busy is held low: every pipeline stage advances each cycle and the receiver
// cannot stall, so nothing ever waits.
// Reset (i_rst_n, synchronous, active low) clears the stage valid bits and the strobe;
// data registers are not reset.
`default_nettype none
module gregorian_date_difference_top (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [gdd_pkg::YEAR_W-1:0]  i_first_year,
    input  wire logic [gdd_pkg::MONTH_W-1:0] i_first_month,
    input  wire logic [gdd_pkg::DAY_W-1:0]   i_first_day,
    input  wire logic [gdd_pkg::YEAR_W-1:0]  i_second_year,
    input  wire logic [gdd_pkg::MONTH_W-1:0] i_second_month,
    input  wire logic [gdd_pkg::DAY_W-1:0]   i_second_day,
    output logic                             o_strobe,
    output logic signed [gdd_pkg::DIFF_W-1:0] o_day_difference,
    output logic                             o_first_valid,
    output logic                             o_second_valid,
    output logic                             o_first_earlier,
    output logic                             o_first_later,
    output logic                             o_dates_equal
);
    import gdd_pkg::*;

    // valid bit per conversion stage; one item may enter every cycle
    logic [CONV_STAGES-1:0] r_vld;
    // raw-field equality travels alongside the item
    logic [CONV_STAGES-1:0] r_eq;

    logic      n_eq;
    t_date_res first_res, second_res;
    logic [DIFF_W-1:0] diff_bits;

    assign busy = 1'b0;
    assign n_eq = (i_first_year == i_second_year) && (i_first_month == i_second_month) &&
                  (i_first_day == i_second_day);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[CONV_STAGES-2:0], start};
        end
    end

    always_ff @(posedge i_clk) begin
        r_eq <= {r_eq[CONV_STAGES-2:0], n_eq};
    end

    // each date becomes a serial day number in three stages
    gdd_date_conv u_conv_first (
        .i_clk   (i_clk),
        .i_year  (i_first_year),
        .i_month (i_first_month),
        .i_day   (i_first_day),
        .o_res   (first_res)
    );

    gdd_date_conv u_conv_second (
        .i_clk   (i_clk),
        .i_year  (i_second_year),
        .i_month (i_second_month),
        .i_day   (i_second_day),
        .o_res   (second_res)
    );

    // difference with saturation, ordering flags, output register
    gdd_compare u_compare (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_vld           (r_vld[CONV_STAGES-1]),
        .i_eq            (r_eq[CONV_STAGES-1]),
        .i_first         (first_res),
        .i_second        (second_res),
        .o_strobe        (o_strobe),
        .o_diff          (diff_bits),
        .o_first_valid   (o_first_valid),
        .o_second_valid  (o_second_valid),
        .o_first_earlier (o_first_earlier),
        .o_first_later   (o_first_later),
        .o_equal         (o_dates_equal)
    );

    assign o_day_difference = diff_bits;

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`default_nettype none
module tb;
    import gdd_pkg::*;

    // One item: a pair of raw dates, each field at the port width.
    typedef struct packed {
        logic [YEAR_W-1:0]  first_year;
        logic [MONTH_W-1:0] first_month;
        logic [DAY_W-1:0]   first_day;
        logic [YEAR_W-1:0]  second_year;
        logic [MONTH_W-1:0] second_month;
        logic [DAY_W-1:0]   second_day;
    } t_date_pair;

    // One result, as seen on the output ports.
    typedef struct packed {
        logic signed [DIFF_W-1:0] day_difference;
        logic                     first_valid;
        logic                     second_valid;
        logic                     first_earlier;
        logic                     first_later;
        logic                     dates_equal;
    } t_outcome;

    // Works out the serial day numbers of both dates and keeps the outcomes
    // still due from the block, oldest first.
    class date_diff_scoreboard;
        t_outcome expected_outcomes[$];
        int       mismatches;

        function new();
            mismatches = 0;
        endfunction

        function bit is_leap(int unsigned y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        // zero for a month that does not exist
        function int unsigned days_in_month(int unsigned y, int unsigned m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                MONTH_FEB:             return is_leap(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        // common-year days before month m; months past December count a whole year
        function int month_offset(int unsigned m);
            int acc;
            acc = 0;
            if (m > MONTH_DEC)
                return 365;
            for (int unsigned k = 1; k < m; k++)
                acc += days_in_month(1, k);
            return acc;
        endfunction

        function int serial_day(int unsigned y, int unsigned m, int unsigned d);
            int prior;
            int p;
            if (y == 0) begin
                prior = -365;
            end else begin
                p     = y - 1;
                prior = 365 * p + p / 4 - p / 100 + p / 400;
            end
            return prior + month_offset(m) + int'(d)
                   + ((m > MONTH_FEB && is_leap(y)) ? 1 : 0);
        endfunction

        function bit date_legal(int unsigned y, int unsigned m, int unsigned d);
            return d != 0 && d <= days_in_month(y, m);
        endfunction

        function void note_item(t_date_pair p);
            t_outcome o;
            int       s1;
            int       s2;
            int       diff;
            s1   = serial_day(p.first_year, p.first_month, p.first_day);
            s2   = serial_day(p.second_year, p.second_month, p.second_day);
            diff = s1 - s2;
            if (diff > 4194303)
                diff = 4194303;
            if (diff < -4194304)
                diff = -4194304;
            o.day_difference = diff[DIFF_W-1:0];
            o.first_valid    = date_legal(p.first_year, p.first_month, p.first_day);
            o.second_valid   = date_legal(p.second_year, p.second_month, p.second_day);
            o.first_earlier  = s1 < s2;
            o.first_later    = s1 > s2;
            o.dates_equal    = p.first_year == p.second_year
                               && p.first_month == p.second_month
                               && p.first_day == p.second_day;
            expected_outcomes.push_back(o);
        endfunction

        function void check_result(t_outcome got);
            t_outcome want;
            if (expected_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: diff=%0d valid=%b%b lt=%b gt=%b eq=%b",
                             got.day_difference, got.first_valid, got.second_valid,
                             got.first_earlier, got.first_later, got.dates_equal);
                return;
            end
            want = expected_outcomes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: exp diff=%0d valid=%b%b lt=%b gt=%b eq=%b",
                             want.day_difference, want.first_valid, want.second_valid,
                             want.first_earlier, want.first_later, want.dates_equal);
                    $display("          got diff=%0d valid=%b%b lt=%b gt=%b eq=%b",
                             got.day_difference, got.first_valid, got.second_valid,
                             got.first_earlier, got.first_later, got.dates_equal);
                end
            end
        endfunction

        function int pending();
            return expected_outcomes.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [YEAR_W-1:0]         i_first_year;
    logic [MONTH_W-1:0]        i_first_month;
    logic [DAY_W-1:0]          i_first_day;
    logic [YEAR_W-1:0]         i_second_year;
    logic [MONTH_W-1:0]        i_second_month;
    logic [DAY_W-1:0]          i_second_day;
    logic                      o_strobe;
    logic signed [DIFF_W-1:0]  o_day_difference;
    logic                      o_first_valid;
    logic                      o_second_valid;
    logic                      o_first_earlier;
    logic                      o_first_later;
    logic                      o_dates_equal;

    date_diff_scoreboard sb;
    int                  burst_mode;

    gregorian_date_difference_top u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_first_year     (i_first_year),
        .i_first_month    (i_first_month),
        .i_first_day      (i_first_day),
        .i_second_year    (i_second_year),
        .i_second_month   (i_second_month),
        .i_second_day     (i_second_day),
        .o_strobe         (o_strobe),
        .o_day_difference (o_day_difference),
        .o_first_valid    (o_first_valid),
        .o_second_valid   (o_second_valid),
        .o_first_earlier  (o_first_earlier),
        .o_first_later    (o_first_later),
        .o_dates_equal    (o_dates_equal)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Monitor: everything is sampled at the edge, before the edge's own updates land.
    // An item counts as taken when start is high and busy low; a result is taken
    // on any cycle with the strobe up (the receiver has no way to push back).
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                sb.note_item('{i_first_year, i_first_month, i_first_day,
                               i_second_year, i_second_month, i_second_day});
            if (o_strobe)
                sb.check_result('{o_day_difference, o_first_valid, o_second_valid,
                                  o_first_earlier, o_first_later, o_dates_equal});
        end
    end

    function automatic t_date_pair pair_of(int y1, int m1, int d1, int y2, int m2, int d2);
        t_date_pair p;
        p.first_year   = y1[YEAR_W-1:0];
        p.first_month  = m1[MONTH_W-1:0];
        p.first_day    = d1[DAY_W-1:0];
        p.second_year  = y2[YEAR_W-1:0];
        p.second_month = m2[MONTH_W-1:0];
        p.second_day   = d2[DAY_W-1:0];
        return p;
    endfunction

    // Gap for the next item; in a burst stretch the sender never idles.
    function automatic int draw_gap();
        return burst_mode ? 0 : $urandom_range(0, 10);
    endfunction

    // Called in the time step of an edge (right after reset or a previous
    // acceptance). With no gap the next item goes straight on, so start is
    // never dropped and raised in one step.
    task automatic drive_item(t_date_pair p, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start          <= 1'b1;
        i_first_year   <= p.first_year;
        i_first_month  <= p.first_month;
        i_first_day    <= p.first_day;
        i_second_year  <= p.second_year;
        i_second_month <= p.second_month;
        i_second_day   <= p.second_day;
        do @(posedge i_clk); while (busy);
    endtask

    // Sender holds off until every outcome has come back; the first edge lets
    // the monitor note the item taken at the edge just passed.
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() > 0)
            @(posedge i_clk);
    endtask

    // Random pair: mostly legal dates (near each other now and then, so the
    // ordering flags see small differences), some with one date broken, and
    // some with every field drawn over its full width.
    function automatic t_date_pair random_pair();
        t_date_pair p;
        int         kind;
        int         y;
        int         m;
        logic [63:0] raw;
        kind = $urandom_range(0, 99);
        y    = $urandom_range(1, 9999);
        m    = $urandom_range(1, 12);
        p.first_year  = YEAR_W'(y);
        p.first_month = MONTH_W'(m);
        p.first_day   = DAY_W'($urandom_range(1, sb.days_in_month(y, m)));
        case ($urandom_range(0, 3))
            0: begin
                p.second_year  = p.first_year;
                p.second_month = p.first_month;
                p.second_day   = p.first_day;
            end
            1: begin
                y = p.first_year + $urandom_range(0, 2) - 1;
                if (y < 1)
                    y = 1;
                m = $urandom_range(1, 12);
                p.second_year  = YEAR_W'(y);
                p.second_month = MONTH_W'(m);
                p.second_day   = DAY_W'($urandom_range(1, sb.days_in_month(y, m)));
            end
            default: begin
                y = $urandom_range(1, 9999);
                m = $urandom_range(1, 12);
                p.second_year  = YEAR_W'(y);
                p.second_month = MONTH_W'(m);
                p.second_day   = DAY_W'($urandom_range(1, sb.days_in_month(y, m)));
            end
        endcase
        if (kind >= 90) begin
            raw = {$urandom, $urandom};
            p   = raw[$bits(t_date_pair)-1:0];
        end else if (kind >= 70) begin
            if ($urandom_range(0, 1)) begin
                p.first_month = MONTH_W'($urandom);
                p.first_day   = DAY_W'($urandom);
            end else begin
                p.second_month = MONTH_W'($urandom);
                p.second_day   = DAY_W'($urandom);
            end
        end
        return p;
    endfunction

    initial begin
        t_date_pair directed[$];
        int         waited;
        sb         = new();
        burst_mode = 0;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_first_year   <= '0;
        i_first_month  <= '0;
        i_first_day    <= '0;
        i_second_year  <= '0;
        i_second_month <= '0;
        i_second_day   <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: range ends, leap rules, broken months and days, year zero,
        // years past 9999 and both clamps of the difference.
        directed.push_back(pair_of(1, 1, 1, 1, 1, 1));
        directed.push_back(pair_of(9999, 12, 31, 1, 1, 1));
        directed.push_back(pair_of(1, 1, 1, 9999, 12, 31));
        directed.push_back(pair_of(2000, 2, 29, 2000, 3, 1));      // 400-year leap
        directed.push_back(pair_of(1900, 2, 29, 1900, 3, 1));      // century, not leap
        directed.push_back(pair_of(2024, 2, 29, 2023, 2, 29));
        directed.push_back(pair_of(2023, 0, 15, 2023, 1, 15));     // month zero
        directed.push_back(pair_of(2023, 13, 1, 2024, 1, 1));      // same serial, fields differ
        directed.push_back(pair_of(2024, 15, 31, 2024, 14, 0));    // month past Dec, leap; day 0
        directed.push_back(pair_of(2023, 4, 31, 2023, 4, 30));     // day past month end
        directed.push_back(pair_of(2023, 6, 0, 2023, 6, 0));       // equal but invalid
        directed.push_back(pair_of(0, 1, 1, 1, 1, 1));             // year zero
        directed.push_back(pair_of(0, 3, 1, 0, 2, 29));            // year zero is leap
        directed.push_back(pair_of(16383, 15, 31, 0, 0, 0));       // clamps high
        directed.push_back(pair_of(0, 0, 0, 16383, 15, 31));       // clamps low
        directed.push_back(pair_of(10000, 1, 1, 9999, 12, 31));
        directed.push_back(pair_of(12345, 6, 15, 12345, 6, 15));
        directed.push_back(pair_of(2100, 2, 28, 2100, 3, 1));
        directed.push_back(pair_of(2400, 12, 31, 2400, 1, 1));
        directed.push_back(pair_of(1, 12, 31, 2, 1, 1));
        directed.push_back(pair_of(8191, 7, 31, 4096, 8, 16));
        directed.push_back(pair_of(5461, 10, 21, 10922, 5, 10));
        foreach (directed[i])
            drive_item(directed[i], draw_gap());
        drain();

        // Random: stretches of back-to-back items mixed with idle gaps, and a
        // full drain every so often.
        for (int n = 0; n < 1350; n++) begin
            if (n % 64 == 0)
                burst_mode = ($urandom_range(0, 2) == 0);
            if (n % 450 == 449)
                drain();
            drive_item(random_pair(), draw_gap());
        end
        start <= 1'b0;

        waited = 0;
        while (sb.pending() > 0 && waited < 1000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        if (sb.pending() > 0) begin
            sb.mismatches++;
            $display("%0d outcomes never arrived", sb.pending());
        end

        if (sb.mismatches == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    // Watchdog, well beyond the slowest legal run.
    initial begin
        #400000;
        $display("tb: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/gdd_pkg.sv
rtl/gdd_date_conv.sv
rtl/gdd_compare.sv
rtl/gregorian_date_difference_top.sv
tb/tb.sv
